// ===== rtl/tlpt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpt_pkg
// Shared widths, request codes, status codes and entry flag constants for the
// two-level page table manager.
// ----------------------------------------------------------------------------
package tlpt_pkg;

  localparam int DIR_ENTRIES_DEF = 16;

  localparam int ADDR_W   = 32;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int FLAGS_W  = 12;
  localparam int OFS_W    = 12;
  localparam int TIDX_W   = 10;
  localparam int TABLE_SPAN = 1 << TIDX_W;
  localparam int TIDX_LSB = OFS_W;
  localparam int DIR_LSB  = OFS_W + TIDX_W;
  localparam int DIR_FIELD_W = ADDR_W - DIR_LSB;

  localparam logic [KIND_W-1:0] KIND_XLATE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MAP   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_UNMAP = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNMAPPED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

  localparam logic [ADDR_W-1:0] ENT_PRESENT = 32'h0000_0001;
  localparam logic [ADDR_W-1:0] ENT_WRITE   = 32'h0000_0002;
  localparam logic [ADDR_W-1:0] ENT_USER    = 32'h0000_0004;
  localparam logic [ADDR_W-1:0] ENT_OWNED   = 32'h0000_0200;
  localparam logic [ADDR_W-1:0] BASE_MASK   = 32'hFFFF_F000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   phys_addr;
    logic [ADDR_W-1:0]   free_frame;
    logic                free_valid;
    logic                took_table_frame;
    logic                took_page_frame;
  } tlpt_rsp_t;

endpackage

// ===== rtl/tlpt_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpt_req_if
// Request channel: valid/ready handshake with the request payload.
// ----------------------------------------------------------------------------
interface tlpt_req_if import tlpt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [ADDR_W-1:0]   virt_addr;
  logic [ADDR_W-1:0]   phys_addr_in;
  logic [FLAGS_W-1:0]  entry_flags;
  logic [ADDR_W-1:0]   table_frame;
  logic [ADDR_W-1:0]   page_frame;

  modport source (
    output valid, kind, virt_addr, phys_addr_in, entry_flags, table_frame, page_frame,
    input  ready
  );
  modport sink (
    input  valid, kind, virt_addr, phys_addr_in, entry_flags, table_frame, page_frame,
    output ready
  );
endinterface

// ===== rtl/tlpt_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpt_rsp_if
// Result channel: valid/ready handshake with the result payload.
// ----------------------------------------------------------------------------
interface tlpt_rsp_if import tlpt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   phys_addr_out;
  logic [ADDR_W-1:0]   free_frame;
  logic                free_valid;
  logic                took_table_frame;
  logic                took_page_frame;

  modport source (
    output valid, status, phys_addr_out, free_frame, free_valid, took_table_frame,
           took_page_frame,
    input  ready
  );
  modport sink (
    input  valid, status, phys_addr_out, free_frame, free_valid, took_table_frame,
           took_page_frame,
    output ready
  );
endinterface

// ===== rtl/tlpt_tbl_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpt_tbl_ram
// Page table store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tlpt_tbl_ram import tlpt_pkg::*; #(
  parameter int DEPTH = DIR_ENTRIES_DEF * TABLE_SPAN,
  parameter int AW    = $clog2(DIR_ENTRIES_DEF * TABLE_SPAN),
  parameter int DW    = ADDR_W
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/two_level_page_table_manager.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_page_table_manager
// Two-level page directory / page table store with translate, map and unmap.
// ----------------------------------------------------------------------------
// One request is handled at a time. Translate, unmap and map into an existing
// table pass through directory read, table read, read-modify-write of the table
// entry and result register. A translate or unmap that finds no directory entry
// skips the table step. Out-of-range and unknown requests go straight to the
// result register. A map that creates a new table adds a clearing sweep, one
// table entry per cycle through the table memory write port. After reset the
// directory memory is cleared before the first request is taken. A finished
// result is held in the output register; the next request may be accepted
// and worked on while it waits.
// ----------------------------------------------------------------------------
module two_level_page_table_manager import tlpt_pkg::*; #(
  parameter int DIR_ENTRIES = DIR_ENTRIES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tlpt_req_if.sink   in_ch,
  tlpt_rsp_if.source out_ch
);

  localparam int DIR_AW    = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
  localparam int TBL_AW    = DIR_AW + TIDX_W;
  localparam int TBL_DEPTH = DIR_ENTRIES * TABLE_SPAN;
  localparam logic [TIDX_W-1:0]      DIR_LAST  = TIDX_W'(DIR_ENTRIES - 1);
  localparam logic [TIDX_W-1:0]      TIDX_LAST = '1;
  localparam logic [DIR_FIELD_W:0]   DIR_LIMIT = (DIR_FIELD_W + 1)'(DIR_ENTRIES);

  typedef enum logic [5:0] {
    S_INIT = 6'b000001,
    S_IDLE = 6'b000010,
    S_DIR  = 6'b000100,
    S_CLR  = 6'b001000,
    S_TBL  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [TIDX_W-1:0]   pos_r, pos_nxt;
  logic                fresh_r, fresh_nxt;
  logic                out_valid_r, out_valid_nxt;
  tlpt_rsp_t           res_r, res_nxt;
  tlpt_rsp_t           out_r, out_nxt;

  logic [KIND_W-1:0]   kind_r;
  logic [DIR_AW-1:0]   dir_r;
  logic [TIDX_W-1:0]   tidx_r;
  logic [OFS_W-1:0]    ofs_r;
  logic [ADDR_W-1:0]   pa_r;
  logic [FLAGS_W-1:0]  flags_r;
  logic [ADDR_W-1:0]   tframe_r;
  logic [ADDR_W-1:0]   pframe_r;

  logic [ADDR_W-1:0]   dir_mem [DIR_ENTRIES];
  logic [ADDR_W-1:0]   dir_rd_r;
  logic                dir_we;
  logic [DIR_AW-1:0]   dir_wa;
  logic [ADDR_W-1:0]   dir_wd;
  logic [DIR_AW-1:0]   in_dir_idx;

  logic                tbl_we;
  logic [TBL_AW-1:0]   tbl_wa;
  logic [ADDR_W-1:0]   tbl_wd;
  logic [TBL_AW-1:0]   tbl_ra;
  logic [ADDR_W-1:0]   tbl_rd;

  logic                accept;
  logic                in_range;
  logic [ADDR_W-1:0]   entry;
  logic [ADDR_W-1:0]   flags_w;
  logic                owned;

  assign accept     = in_ch.valid && in_ch.ready;
  assign in_dir_idx = in_ch.virt_addr[DIR_LSB +: DIR_AW];
  assign in_range   = {1'b0, in_ch.virt_addr[ADDR_W-1:DIR_LSB]} < DIR_LIMIT;
  assign tbl_ra     = {dir_r, tidx_r};
  assign entry      = fresh_r ? '0 : tbl_rd;
  assign owned      = (entry & ENT_OWNED) != '0;
  assign flags_w    = {{(ADDR_W-FLAGS_W){1'b0}}, flags_r};

  assign in_ch.ready             = (state_r == S_IDLE);
  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = out_r.status;
  assign out_ch.phys_addr_out    = out_r.phys_addr;
  assign out_ch.free_frame       = out_r.free_frame;
  assign out_ch.free_valid       = out_r.free_valid;
  assign out_ch.took_table_frame = out_r.took_table_frame;
  assign out_ch.took_page_frame  = out_r.took_page_frame;

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    fresh_nxt     = fresh_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    dir_we        = 1'b0;
    dir_wa        = dir_r;
    dir_wd        = tframe_r | flags_w | ENT_PRESENT | ENT_WRITE | ENT_USER;
    tbl_we        = 1'b0;
    tbl_wa        = tbl_ra;
    tbl_wd        = '0;
    unique case (state_r)
      S_INIT: begin
        dir_we = 1'b1;
        dir_wa = pos_r[DIR_AW-1:0];
        dir_wd = '0;
        if (pos_r == DIR_LAST) begin
          pos_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          pos_nxt = pos_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (accept) begin
          res_nxt   = '0;
          fresh_nxt = 1'b0;
          if (!in_range) begin
            res_nxt.status = ST_RANGE;
            state_nxt      = S_DONE;
          end else if (in_ch.kind == KIND_XLATE || in_ch.kind == KIND_MAP ||
                       in_ch.kind == KIND_UNMAP) begin
            state_nxt = S_DIR;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DIR: begin
        if (dir_rd_r == '0) begin
          if (kind_r == KIND_XLATE) begin
            res_nxt.status = ST_UNMAPPED;
            state_nxt      = S_DONE;
          end else if (kind_r == KIND_MAP) begin
            dir_we                   = 1'b1;
            res_nxt.took_table_frame = 1'b1;
            pos_nxt                  = '0;
            state_nxt                = S_CLR;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          state_nxt = S_TBL;
        end
      end
      S_CLR: begin
        tbl_we = 1'b1;
        tbl_wa = {dir_r, pos_r};
        if (pos_r == TIDX_LAST) begin
          pos_nxt   = '0;
          fresh_nxt = 1'b1;
          state_nxt = S_TBL;
        end else begin
          pos_nxt = pos_r + 1'b1;
        end
      end
      S_TBL: begin
        state_nxt = S_DONE;
        if (kind_r == KIND_XLATE) begin
          if (entry == '0) begin
            res_nxt.status = ST_UNMAPPED;
          end else begin
            res_nxt.phys_addr = (entry & BASE_MASK) | {{(ADDR_W-OFS_W){1'b0}}, ofs_r};
          end
        end else if (kind_r == KIND_MAP) begin
          tbl_we = 1'b1;
          if (pa_r == '0) begin
            if (owned) begin
              tbl_wd = (entry & BASE_MASK) | flags_w | ENT_PRESENT | ENT_OWNED;
            end else begin
              tbl_wd                  = pframe_r | flags_w | ENT_PRESENT | ENT_OWNED;
              res_nxt.took_page_frame = 1'b1;
            end
          end else begin
            if (owned) begin
              res_nxt.free_frame = entry & BASE_MASK;
              res_nxt.free_valid = 1'b1;
            end
            tbl_wd = pa_r | flags_w | ENT_PRESENT;
          end
        end else begin
          tbl_we = 1'b1;
          tbl_wd = '0;
          if (owned) begin
            res_nxt.free_frame = entry & BASE_MASK;
            res_nxt.free_valid = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
        pos_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      pos_r       <= '0;
      fresh_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    out_r <= out_nxt;
    if (accept) begin
      kind_r   <= in_ch.kind;
      dir_r    <= in_dir_idx;
      tidx_r   <= in_ch.virt_addr[TIDX_LSB +: TIDX_W];
      ofs_r    <= in_ch.virt_addr[OFS_W-1:0];
      pa_r     <= in_ch.phys_addr_in & BASE_MASK;
      flags_r  <= in_ch.entry_flags;
      tframe_r <= in_ch.table_frame & BASE_MASK;
      pframe_r <= in_ch.page_frame & BASE_MASK;
    end
  end

  // directory memory: written by the init sweep or a new table, read at accept
  always_ff @(posedge clk) begin
    if (dir_we) begin
      dir_mem[dir_wa] <= dir_wd;
    end
  end

  always_ff @(posedge clk) begin
    dir_rd_r <= dir_mem[in_dir_idx];
  end

  tlpt_tbl_ram #(
    .DEPTH (TBL_DEPTH),
    .AW    (TBL_AW),
    .DW    (ADDR_W)
  ) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_wa),
    .wdata (tbl_wd),
    .raddr (tbl_ra),
    .rdata (tbl_rd)
  );

endmodule

// ===== bench/two_level_page_table_manager_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_page_table_manager_test
// Self-checking bench for the page table manager. It runs a directed set of
// walks, maps and unmaps, then random traffic aimed at a few hot pages per
// directory slot. Every accepted request is run through a local copy of the
// directory and table stores, and every result is checked field by field.
// The sender works in bursts and the receiver stalls on shifting patterns.
// ----------------------------------------------------------------------------
module two_level_page_table_manager_test import tlpt_pkg::*; ();

  localparam int DIR_SLOTS    = DIR_ENTRIES_DEF;
  localparam int RANDOM_ITEMS = 500;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [ADDR_W-1:0]  virt_addr;
    logic [ADDR_W-1:0]  phys_addr;
    logic [FLAGS_W-1:0] flags;
    logic [ADDR_W-1:0]  table_frame;
    logic [ADDR_W-1:0]  page_frame;
  } page_req_t;

  logic clk;
  logic rst_n;

  tlpt_req_if in_if ();
  tlpt_rsp_if out_if ();

  two_level_page_table_manager #(
    .DIR_ENTRIES (DIR_SLOTS)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  bit [ADDR_W-1:0] dir_mem [DIR_SLOTS];
  bit [ADDR_W-1:0] tbl_mem [DIR_SLOTS * TABLE_SPAN];

  page_req_t request_q [$];
  tlpt_rsp_t expected_rsp_q [$];
  page_req_t cur_req;
  int        mismatches;
  int        cycles;
  int        burst_left;
  int        gap_left;
  logic [15:0] ready_pattern;
  logic [3:0]  ready_pos;
  int          tidx_pool [8];

  always #6 clk = ~clk;

  // Walk and update the local stores for one request, return its result.
  function automatic tlpt_rsp_t walk_and_update(page_req_t r);
    tlpt_rsp_t rsp;
    logic [DIR_FIELD_W-1:0] dir;
    int slot;
    int base;
    int i;
    logic [ADDR_W-1:0] pa;
    logic [ADDR_W-1:0] tf;
    logic [ADDR_W-1:0] pf;
    logic [ADDR_W-1:0] flg;
    logic [ADDR_W-1:0] ent;
    rsp  = '0;
    dir  = r.virt_addr[ADDR_W-1:DIR_LSB];
    pa   = r.phys_addr & BASE_MASK;
    tf   = r.table_frame & BASE_MASK;
    pf   = r.page_frame & BASE_MASK;
    flg  = ADDR_W'(r.flags);
    if (int'(dir) >= DIR_SLOTS) begin
      rsp.status = ST_RANGE;
    end else begin
      base = int'(dir) * TABLE_SPAN;
      slot = base + int'(r.virt_addr[DIR_LSB-1:TIDX_LSB]);
      case (r.kind)
        KIND_XLATE: begin
          if (dir_mem[dir] == '0 || tbl_mem[slot] == '0) begin
            rsp.status = ST_UNMAPPED;
          end else begin
            rsp.phys_addr = (tbl_mem[slot] & BASE_MASK) | ADDR_W'(r.virt_addr[OFS_W-1:0]);
          end
        end
        KIND_MAP: begin
          if (dir_mem[dir] == '0) begin
            dir_mem[dir] = tf | flg | ENT_PRESENT | ENT_WRITE | ENT_USER;
            rsp.took_table_frame = 1'b1;
            for (i = 0; i < TABLE_SPAN; i++) tbl_mem[base + i] = '0;
          end
          ent = tbl_mem[slot];
          if (pa == '0) begin
            if ((ent & ENT_OWNED) != '0) begin
              tbl_mem[slot] = (ent & BASE_MASK) | flg | ENT_PRESENT | ENT_OWNED;
            end else begin
              tbl_mem[slot] = pf | flg | ENT_PRESENT | ENT_OWNED;
              rsp.took_page_frame = 1'b1;
            end
          end else begin
            if ((ent & ENT_OWNED) != '0) begin
              rsp.free_frame = ent & BASE_MASK;
              rsp.free_valid = 1'b1;
            end
            tbl_mem[slot] = pa | flg | ENT_PRESENT;
          end
        end
        KIND_UNMAP: begin
          if (dir_mem[dir] != '0) begin
            ent = tbl_mem[slot];
            if ((ent & ENT_OWNED) != '0) begin
              rsp.free_frame = ent & BASE_MASK;
              rsp.free_valid = 1'b1;
            end
            tbl_mem[slot] = '0;
          end
        end
        default: ;
      endcase
    end
    return rsp;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [ADDR_W-1:0] got, logic [ADDR_W-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s: got %h expected %h", name, got, want));
  endtask

  task automatic add_req(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] va,
                         logic [ADDR_W-1:0] pa, logic [FLAGS_W-1:0] flags,
                         logic [ADDR_W-1:0] tf, logic [ADDR_W-1:0] pf);
    page_req_t r;
    r.kind        = kind;
    r.virt_addr   = va;
    r.phys_addr   = pa;
    r.flags       = flags;
    r.table_frame = tf;
    r.page_frame  = pf;
    request_q.push_back(r);
  endtask

  function automatic logic [ADDR_W-1:0] make_va(int dir, int tidx);
    return {DIR_FIELD_W'(dir), TIDX_W'(tidx), OFS_W'($urandom)};
  endfunction

  // request driver: bursts of requests separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      burst_left = $urandom_range(1, 24);
      gap_left   = 0;
    end else begin
      if (in_if.valid && in_if.ready) expected_rsp_q.push_back(walk_and_update(cur_req));
      if (!in_if.valid || in_if.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (request_q.size() != 0) begin
          cur_req = request_q.pop_front();
          in_if.valid        <= 1'b1;
          in_if.kind         <= cur_req.kind;
          in_if.virt_addr    <= cur_req.virt_addr;
          in_if.phys_addr_in <= cur_req.phys_addr;
          in_if.entry_flags  <= cur_req.flags;
          in_if.table_frame  <= cur_req.table_frame;
          in_if.page_frame   <= cur_req.page_frame;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left--;
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall pattern
  always @(posedge clk) begin
    tlpt_rsp_t exp_rsp;
    if (!rst_n) begin
      out_if.ready  <= 1'b0;
      ready_pattern = 16'hFFFF;
      ready_pos     = '0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          check_field("status", ADDR_W'(out_if.status), ADDR_W'(exp_rsp.status));
          check_field("phys_addr_out", out_if.phys_addr_out, exp_rsp.phys_addr);
          check_field("free_frame", out_if.free_frame, exp_rsp.free_frame);
          check_field("free_valid", ADDR_W'(out_if.free_valid), ADDR_W'(exp_rsp.free_valid));
          check_field("took_table_frame", ADDR_W'(out_if.took_table_frame),
                      ADDR_W'(exp_rsp.took_table_frame));
          check_field("took_page_frame", ADDR_W'(out_if.took_page_frame),
                      ADDR_W'(exp_rsp.took_page_frame));
        end
      end
      out_if.ready <= ready_pattern[ready_pos];
      ready_pos = ready_pos + 1'b1;
      if (ready_pos == '0) begin
        case ($urandom_range(0, 4))
          0, 1: ready_pattern = 16'hFFFF;
          2:    ready_pattern = 16'($urandom);
          3:    ready_pattern = 16'($urandom) | 16'($urandom);
          default: ready_pattern = 16'h0101;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int n;
    int pick;
    int dir;
    int tidx;
    logic [ADDR_W-1:0] va;
    clk                = 1'b0;
    rst_n              = 1'b0;
    mismatches         = 0;
    cycles             = 0;
    in_if.valid        = 1'b0;
    in_if.kind         = KIND_XLATE;
    in_if.virt_addr    = '0;
    in_if.phys_addr_in = '0;
    in_if.entry_flags  = '0;
    in_if.table_frame  = '0;
    in_if.page_frame   = '0;
    out_if.ready       = 1'b0;

    // empty store, unknown kind and out of range for every kind
    add_req(KIND_XLATE, 32'h0000_0000, '0, '0, '0, '0);
    add_req(KIND_UNMAP, 32'h0000_0000, '0, '0, '0, '0);
    add_req(KIND_NONE,  32'h0000_0000, 32'hFFFF_FFFF, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_req(KIND_XLATE, 32'hFFFF_FFFF, '0, '0, '0, '0);
    add_req(KIND_MAP,   32'h0400_0000, 32'hFFFF_FFFF, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_req(KIND_UNMAP, {DIR_FIELD_W'(DIR_SLOTS), 22'h3F_FFFF}, '0, '0, '0, '0);
    add_req(KIND_NONE,  32'hFFC0_0000, '0, '0, '0, '0);
    // anonymous page, reuse of the owned frame, then direct map frees it
    add_req(KIND_MAP,   32'h0000_0000, '0, 12'h000, 32'h0000_1ABC, 32'hFFFF_FFFF);
    add_req(KIND_XLATE, 32'h0000_0FFF, '0, '0, '0, '0);
    add_req(KIND_MAP,   32'h0000_0123, '0, 12'hFFF, 32'h0000_2000, 32'h0000_3FFF);
    add_req(KIND_MAP,   32'h0000_0000, 32'hFFFF_FFFF, 12'h000, 32'h0000_4000, 32'h0000_5000);
    add_req(KIND_XLATE, 32'h0000_0ABC, '0, '0, '0, '0);
    add_req(KIND_UNMAP, 32'h0000_0000, '0, '0, '0, '0);
    add_req(KIND_XLATE, 32'h0000_0000, '0, '0, '0, '0);
    // direct map carrying the owned flag at the top of the store
    add_req(KIND_MAP,   32'h03FF_FFFF, 32'h1234_5FFF, 12'h200, 32'hFFFF_FFFF, 32'h0000_0FFF);
    add_req(KIND_XLATE, 32'h03FF_FFFF, '0, '0, '0, '0);
    add_req(KIND_UNMAP, 32'h03FF_F000, '0, '0, '0, '0);
    add_req(KIND_MAP,   32'h03FF_F000, '0, 12'h5A5, 32'h0000_7000, 32'hABCD_E123);
    add_req(KIND_NONE,  32'h03FF_F000, '0, '0, '0, '0);
    add_req(KIND_UNMAP, 32'h03C0_0000, '0, '0, '0, '0);
    add_req(KIND_XLATE, 32'h03C0_0000, '0, '0, '0, '0);

    tidx_pool[0] = 0;
    tidx_pool[1] = TABLE_SPAN - 1;
    for (int i = 2; i < 8; i++) tidx_pool[i] = $urandom_range(0, TABLE_SPAN - 1);

    n = 0;
    while (n < RANDOM_ITEMS) begin
      dir  = $urandom_range(0, DIR_SLOTS - 1);
      tidx = ($urandom_range(0, 4) == 0) ? $urandom_range(0, TABLE_SPAN - 1)
                                         : tidx_pool[$urandom_range(0, 7)];
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        // full lifecycle of one page with random content
        add_req(KIND_MAP, make_va(dir, tidx), '0, 12'($urandom), $urandom, $urandom);
        add_req(KIND_MAP, make_va(dir, tidx), '0, 12'($urandom), $urandom, $urandom);
        add_req(KIND_XLATE, make_va(dir, tidx), $urandom, 12'($urandom), $urandom, $urandom);
        add_req(KIND_MAP, make_va(dir, tidx), $urandom | 32'h0000_1000, 12'($urandom),
                $urandom, $urandom);
        add_req(KIND_UNMAP, make_va(dir, tidx), $urandom, 12'($urandom), $urandom, $urandom);
        n += 5;
      end else begin
        va = make_va(dir, tidx);
        if (pick < 50) begin
          add_req(KIND_MAP, va, ($urandom_range(0, 1) == 0) ? '0 : $urandom,
                  12'($urandom), $urandom, $urandom);
        end else if (pick < 75) begin
          add_req(KIND_XLATE, va, $urandom, 12'($urandom), $urandom, $urandom);
        end else if (pick < 91) begin
          add_req(KIND_UNMAP, va, $urandom, 12'($urandom), $urandom, $urandom);
        end else if (pick < 94) begin
          add_req(KIND_NONE, va, $urandom, 12'($urandom), $urandom, $urandom);
        end else begin
          va = {DIR_FIELD_W'($urandom_range(DIR_SLOTS, (1 << DIR_FIELD_W) - 1)),
                22'($urandom)};
          add_req(KIND_W'($urandom_range(0, 3)), va, $urandom, 12'($urandom),
                  $urandom, $urandom);
        end
        n++;
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    @(posedge clk);
    while (request_q.size() != 0 || in_if.valid || expected_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
